### src/bus_voltage_fault_monitor_macros.svh
// Assertion macros shared by the bus voltage fault monitor.
`ifndef BUS_VOLTAGE_FAULT_MONITOR_MACROS_SVH
`define BUS_VOLTAGE_FAULT_MONITOR_MACROS_SVH

// Checked on every rising edge outside of reset.
`define BVFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BVFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bvfm_pkg.sv
// Types, codes and constants of the bus voltage fault monitor.
`timescale 1ns / 1ps
package bvfm_pkg;

  localparam int ADC_BITS = 12;
  localparam int FIELD_W  = 12;
  localparam int CMP_W    = (ADC_BITS > FIELD_W) ? ADC_BITS : FIELD_W;
  localparam int PCT_W    = 7;
  localparam int PROD_W   = CMP_W + PCT_W;
  localparam int OV_CNT_W = 8;
  localparam int UV_CNT_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [OV_CNT_W-1:0] OV_SAT       = 8'd255;
  localparam logic [FIELD_W-1:0]  UV_LOW_SPEED = 12'd200;
  localparam logic [PCT_W-1:0]    PCT_SCALE    = 7'd100;

  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_PID   = 2'd2;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_OV   = 2'd1;
  localparam logic [1:0] FAULT_UV   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OV_THRESHOLD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OV_TRIP_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UV_PERCENT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UV_SAT_PERCENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UV_TRIP_COUNT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UV_SAT_TRIP_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW_SPEED     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_SAT_LEVEL     = 3'd7;

  typedef struct packed {
    logic [ADC_BITS-1:0] bus_high_adc;
    logic [ADC_BITS-1:0] bus_low_adc;
    logic [1:0]          motor_mode;
    logic [FIELD_W-1:0]  pwm_duty;
    logic [FIELD_W-1:0]  speed_scale;
    logic [FIELD_W-1:0]  target_voltage;
  } in_t;

  typedef struct packed {
    logic [1:0]          fault_code;
    logic [ADC_BITS-1:0] bus_voltage;
  } out_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  ov_threshold;
    logic [OV_CNT_W-1:0] ov_trip_count;
    logic [PCT_W-1:0]    uv_percent;
    logic [PCT_W-1:0]    uv_sat_percent;
    logic [UV_CNT_W-1:0] uv_trip_count;
    logic [UV_CNT_W-1:0] uv_sat_trip_count;
    logic [FIELD_W-1:0]  sat_low_speed;
    logic [FIELD_W-1:0]  pwm_sat_level;
  } cfg_t;

endpackage

### src/bvfm_cfg_regs.sv
// Configuration register bank of the bus voltage fault monitor.
`timescale 1ns / 1ps
module bvfm_cfg_regs import bvfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ov_threshold      <= 12'd928;
      cfg.ov_trip_count     <= 8'd16;
      cfg.uv_percent        <= 7'd80;
      cfg.uv_sat_percent    <= 7'd94;
      cfg.uv_trip_count     <= 16'd1440;
      cfg.uv_sat_trip_count <= 16'd3200;
      cfg.sat_low_speed     <= 12'd300;
      cfg.pwm_sat_level     <= 12'd998;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OV_THRESHOLD:      cfg.ov_threshold      <= cfg_data[FIELD_W-1:0];
        REG_OV_TRIP_COUNT:     cfg.ov_trip_count     <= cfg_data[OV_CNT_W-1:0];
        REG_UV_PERCENT:        cfg.uv_percent        <= cfg_data[PCT_W-1:0];
        REG_UV_SAT_PERCENT:    cfg.uv_sat_percent    <= cfg_data[PCT_W-1:0];
        REG_UV_TRIP_COUNT:     cfg.uv_trip_count     <= cfg_data[UV_CNT_W-1:0];
        REG_UV_SAT_TRIP_COUNT: cfg.uv_sat_trip_count <= cfg_data[UV_CNT_W-1:0];
        REG_SAT_LOW_SPEED:     cfg.sat_low_speed     <= cfg_data[FIELD_W-1:0];
        REG_PWM_SAT_LEVEL:     cfg.pwm_sat_level     <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/bvfm_check.sv
// Bus voltage computation with the overvoltage and undervoltage counters.
`timescale 1ns / 1ps
module bvfm_check import bvfm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  logic [OV_CNT_W-1:0] ov_counter, ov_counter_next, ov_step;
  logic [UV_CNT_W-1:0] uv_counter, uv_counter_next, uv_inc, uv_limit;
  logic [ADC_BITS-1:0] volt;
  logic [CMP_W-1:0]    volt_ext;
  logic [PROD_W-1:0]   volt_scaled, target_scaled;
  logic [PCT_W-1:0]    pct;
  logic                sat, run_mode;
  logic [1:0]          fault;

  always_comb begin
    volt = (item.bus_high_adc > item.bus_low_adc) ?
           (item.bus_high_adc - item.bus_low_adc) : '0;
    volt_ext = CMP_W'(volt);

    // Up/down count, held within 0..255.
    if (volt_ext >= CMP_W'(cfg.ov_threshold)) begin
      ov_step = (ov_counter != OV_SAT) ? ov_counter + 1'b1 : ov_counter;
    end else begin
      ov_step = (ov_counter != '0) ? ov_counter - 1'b1 : ov_counter;
    end

    sat      = item.pwm_duty >= cfg.pwm_sat_level;
    pct      = sat ? cfg.uv_sat_percent : cfg.uv_percent;
    uv_limit = sat ? cfg.uv_sat_trip_count : cfg.uv_trip_count;
    run_mode = (item.motor_mode == MODE_START) || (item.motor_mode == MODE_PID);
    uv_inc   = (uv_counter != '1) ? uv_counter + 1'b1 : uv_counter;

    volt_scaled   = PROD_W'(volt_ext) * PROD_W'(PCT_SCALE);
    target_scaled = PROD_W'(item.target_voltage) * PROD_W'(pct);

    fault           = FAULT_NONE;
    ov_counter_next = ov_step;
    uv_counter_next = '0;
    priority if (ov_step > cfg.ov_trip_count) begin
      ov_counter_next = '0;
      fault           = FAULT_OV;
    end else if (run_mode && (volt != '0)) begin
      priority if (!sat && (item.speed_scale < UV_LOW_SPEED)) begin
        uv_counter_next = '0;
      end else if (sat && (item.speed_scale < cfg.sat_low_speed)) begin
        uv_counter_next = '0;
      end else if (volt_scaled < target_scaled) begin
        if (uv_inc > uv_limit) begin
          uv_counter_next = '0;
          fault           = FAULT_UV;
        end else begin
          uv_counter_next = uv_inc;
        end
      end else begin
        uv_counter_next = '0;
      end
    end else begin
      uv_counter_next = '0;
    end

    result.fault_code  = fault;
    result.bus_voltage = volt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov_counter <= '0;
      uv_counter <= '0;
    end else if (en) begin
      ov_counter <= ov_counter_next;
      uv_counter <= uv_counter_next;
    end
  end

endmodule

### src/bus_voltage_fault_monitor.sv
// Top level of the bus voltage fault monitor: input register, check logic, result register.
`timescale 1ns / 1ps
// Usage
// One input word is one ADC tick: both bus node samples, the motor mode, the
// PWM duty, the speed scale and the voltage target. Each accepted word
// yields exactly one result word with the fault code and the bus voltage.
// Both channels use valid/stall; a word moves on a rising edge with valid
// high and stall low. Configuration is a plain write port (cfg_wr_en,
// cfg_index, cfg_data) and should be written only while the block is idle.
// The word is captured in an input register, the check logic and both fault
// counters work on it, and the result lands in the output register.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single counter update per word in the check stage.
// When the receiver stalls, the result register holds its word; an empty input
// register still takes one more word, and only then is in_stall raised.
// Synchronous reset empties both registers, clears the two fault counters
// and loads the configuration registers with their default values.
module bus_voltage_fault_monitor import bvfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "bus_voltage_fault_monitor_macros.svh"

  cfg_t cfg;
  in_t  in_reg;
  out_t result;
  logic in_held;
  logic out_adv;
  logic step_en;

  bvfm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register can take a new word when it is empty or being drained.
  assign out_adv  = !out_valid || !out_stall;
  assign step_en  = in_held && out_adv;
  assign in_stall = in_held && !out_adv;

  bvfm_check u_check (
    .clk    (clk),
    .rst    (rst),
    .en     (step_en),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_held <= in_valid;
      end
      if (out_adv) begin
        out_valid <= in_held;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_word;
    end
    if (step_en) begin
      out_word <= result;
    end
  end

  `BVFM_ASSERT(a_stall_only_when_full, in_stall |-> (in_held && out_valid && out_stall), "input stalled without a full pipeline")
  `BVFM_ASSERT(a_uv_fault_has_voltage, (out_valid && (out_word.fault_code == FAULT_UV)) |-> (out_word.bus_voltage != '0), "undervoltage fault reported at zero bus voltage")
  `BVFM_ASSERT(a_result_follows_step, $past(step_en) |-> out_valid, "checked word did not reach the result register")
  `BVFM_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !in_held), "pipeline not empty after reset")

endmodule
